### rtl/core/mtc_pkg.sv
package mtc_pkg;

  // config register indexes
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgTrimX1   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTrimY1   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTrimX2   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTrimY2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTrimXy   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTrimZ1Z2 = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTrimZ3Z4 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgTrimXyz1 = 3'd7;

  // divider: one quotient bit per stage
  localparam int DivW = 32;

  localparam logic [15:0] TOffset  = 16'h4000;
  localparam logic [31:0] BOffset  = 32'h0010_0000;
  localparam logic [31:0] GainBase = 32'd160;
  localparam logic [31:0] ZRound   = 32'h0000_8000;

  typedef struct packed {
    logic [7:0]  x1;
    logic [7:0]  y1;
    logic [7:0]  x2;
    logic [7:0]  y2;
    logic [15:0] xy_pair;
    logic [31:0] z1z2;
    logic [31:0] z3z4;
    logic [15:0] xyz1;
  } cfg_t;

  // values that ride alongside the divider
  typedef struct packed {
    logic signed [12:0] rx;
    logic signed [12:0] ry;
    logic               xy_err;
    logic               z_err;
    logic               z_neg;
  } side_t;

  typedef struct packed {
    logic [DivW:0]   rem;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_lane_t;

  // one restoring step; quotient bits shift into num from the bottom
  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t  o;
    logic [DivW:0] sh;
    logic          qb;
    sh    = {l.rem[DivW-1:0], l.num[DivW-1]};
    qb    = (sh >= {1'b0, l.den});
    o.rem = qb ? (sh - {1'b0, l.den}) : sh;
    o.num = {l.num[DivW-2:0], qb};
    o.den = l.den;
    return o;
  endfunction

endpackage

### rtl/core/mtc_in_if.sv
interface mtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte_0;
  logic [7:0] raw_byte_1;
  logic [7:0] raw_byte_2;
  logic [7:0] raw_byte_3;
  logic [7:0] raw_byte_4;
  logic [7:0] raw_byte_5;
  logic [7:0] raw_byte_6;
  logic [7:0] raw_byte_7;

  modport source (output valid, raw_byte_0, raw_byte_1, raw_byte_2, raw_byte_3,
                  raw_byte_4, raw_byte_5, raw_byte_6, raw_byte_7, input ready);
  modport sink (input valid, raw_byte_0, raw_byte_1, raw_byte_2, raw_byte_3,
                raw_byte_4, raw_byte_5, raw_byte_6, raw_byte_7, output ready);
endinterface

### rtl/core/mtc_out_if.sv
interface mtc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] field_x;
  logic signed [15:0] field_y;
  logic signed [15:0] field_z;
  logic               xy_divide_error;
  logic               z_divide_error;

  modport source (output valid, field_x, field_y, field_z, xy_divide_error,
                  z_divide_error, input ready);
  modport sink (input valid, field_x, field_y, field_z, xy_divide_error,
                z_divide_error, output ready);
endinterface

### rtl/core/magnetometer_trim_compensation.sv
// Magnetometer trim compensation. Takes one 8-byte sensor burst per word on
// in_i and returns compensated X/Y/Z fields plus divide-error flags on out_o.
// Bursts with the data-ready bit (byte 6 bit 0) clear are accepted and dropped.
// Throughput: one word per cycle unless out_o stalls. Pipeline: 39 register stages
// (2 front stages, 32 divider stages at one quotient bit each for the resistance
// quotient and the Z quotient in parallel, 5 back stages: four with one multiply
// level and a last one that adds the offsets). The whole pipe advances together:
// it stalls only while a finished result waits on out_o, so in_i.ready =
// !out_o.valid || out_o.ready. Trim registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; write them only while the pipe is empty.
module magnetometer_trim_compensation import mtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  mtc_in_if.sink              in_i,
  mtc_out_if.source           out_o
);

  cfg_t cfg_q;

  // trim register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTrimX1:   cfg_q.x1      <= cfg_data_i[7:0];
        CfgTrimY1:   cfg_q.y1      <= cfg_data_i[7:0];
        CfgTrimX2:   cfg_q.x2      <= cfg_data_i[7:0];
        CfgTrimY2:   cfg_q.y2      <= cfg_data_i[7:0];
        CfgTrimXy:   cfg_q.xy_pair <= cfg_data_i[15:0];
        CfgTrimZ1Z2: cfg_q.z1z2    <= cfg_data_i;
        CfgTrimZ3Z4: cfg_q.z3z4    <= cfg_data_i;
        CfgTrimXyz1: cfg_q.xyz1    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // global advance: blocked only by an untaken result
  logic en;
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  logic      f_valid;
  div_lane_t f_xy, f_z;
  side_t     f_side;

  mtc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid && in_i.raw_byte_6[0]),
    .b0_i    (in_i.raw_byte_0),
    .b1_i    (in_i.raw_byte_1),
    .b2_i    (in_i.raw_byte_2),
    .b3_i    (in_i.raw_byte_3),
    .b4_i    (in_i.raw_byte_4),
    .b6_i    (in_i.raw_byte_6[7:2]),
    .b5_i    (in_i.raw_byte_5),
    .b7_i    (in_i.raw_byte_7),
    .cfg_i   (cfg_q),
    .valid_o (f_valid),
    .xy_o    (f_xy),
    .z_o     (f_z),
    .side_o  (f_side)
  );

  logic            d_valid;
  logic [DivW-1:0] d_xy_q, d_z_q;
  side_t           d_side;

  mtc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .xy_i    (f_xy),
    .z_i     (f_z),
    .side_i  (f_side),
    .valid_o (d_valid),
    .xy_q_o  (d_xy_q),
    .z_q_o   (d_z_q),
    .side_o  (d_side)
  );

  logic [15:0] fx, fy, fz;

  mtc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (d_valid),
    .xy_q_i   (d_xy_q),
    .z_q_i    (d_z_q),
    .side_i   (d_side),
    .cfg_i    (cfg_q),
    .valid_o  (out_o.valid),
    .fx_o     (fx),
    .fy_o     (fy),
    .fz_o     (fz),
    .xy_err_o (out_o.xy_divide_error),
    .z_err_o  (out_o.z_divide_error)
  );

  assign out_o.field_x = fx;
  assign out_o.field_y = fy;
  assign out_o.field_z = fz;

  // error flags force their axes to zero
  a_xy_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.xy_divide_error |-> out_o.field_x == 16'd0 && out_o.field_y == 16'd0)
    else $error("xy error with nonzero X/Y");

  a_z_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.z_divide_error |-> out_o.field_z == 16'd0)
    else $error("z error with nonzero Z");

  // a stalled result blocks the input side in the same cycle
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

  // a stalled result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid &&
      $stable({out_o.field_x, out_o.field_y, out_o.field_z}))
    else $error("result changed while stalled");

endmodule

### rtl/core/mtc_front.sv
module mtc_front import mtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  logic [7:0] b0_i,
  input  logic [7:0] b1_i,
  input  logic [7:0] b2_i,
  input  logic [7:0] b3_i,
  input  logic [7:0] b4_i,
  input  logic [5:0] b6_i,
  input  logic [7:0] b5_i,
  input  logic [7:0] b7_i,
  input  cfg_t      cfg_i,
  output logic      valid_o,
  output div_lane_t xy_o,
  output div_lane_t z_o,
  output side_t     side_o
);

  // stage A: unpack, Z products
  logic [13:0] r;
  logic [15:0] divisor;
  logic [31:0] diff, pz3, pz1;

  logic        va_q;
  logic [14:0] rz_q;
  logic [31:0] pz3_q, pz1_q;
  logic [15:0] divisor_q;
  logic signed [12:0] rx_q, ry_q;

  assign r       = {b7_i, b6_i};
  assign divisor = (r != 14'd0) ? {2'b00, r} : cfg_i.xyz1;
  assign diff    = {18'd0, r} - {{16{cfg_i.xyz1[15]}}, cfg_i.xyz1};
  assign pz3     = $signed({{16{cfg_i.z3z4[15]}}, cfg_i.z3z4[15:0]}) * $signed(diff);
  assign pz1     = {16'd0, cfg_i.z1z2[15:0]} * {17'd0, r, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q      <= {b1_i, b0_i[7:3]};
      ry_q      <= {b3_i, b2_i[7:3]};
      rz_q      <= {b5_i, b4_i[7:1]};
      pz3_q     <= pz3;
      pz1_q     <= pz1;
      divisor_q <= divisor;
    end
  end

  // stage B: numerator, denominator, magnitudes
  logic [31:0] t1, num, den, pz1r, nabs, dabs;
  logic        vb_q;

  assign t1   = {{17{rz_q[14]}}, rz_q} - {{16{cfg_i.z3z4[31]}}, cfg_i.z3z4[31:16]};
  assign num  = (t1 << 15) - 32'($signed(pz3_q) >>> 2);
  assign pz1r = pz1_q + ZRound;
  assign den  = {{16{cfg_i.z1z2[31]}}, cfg_i.z1z2[31:16]} + {{16{pz1r[31]}}, pz1r[31:16]};
  assign nabs = num[31] ? (32'd0 - num) : num;
  assign dabs = den[31] ? (32'd0 - den) : den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xy_o.rem      <= '0;
      xy_o.num      <= {2'b00, cfg_i.xyz1, 14'd0};
      xy_o.den      <= {16'd0, divisor_q};
      z_o.rem       <= '0;
      z_o.num       <= nabs;
      z_o.den       <= dabs;
      side_o.rx     <= rx_q;
      side_o.ry     <= ry_q;
      side_o.xy_err <= (divisor_q == 16'd0);
      side_o.z_err  <= (den == 32'd0);
      side_o.z_neg  <= num[31] ^ den[31];
    end
  end

  assign valid_o = vb_q;

endmodule

### rtl/core/mtc_div.sv
module mtc_div import mtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_lane_t xy_i,
  input  div_lane_t z_i,
  input  side_t     side_i,
  output logic      valid_o,
  output logic [DivW-1:0] xy_q_o,
  output logic [DivW-1:0] z_q_o,
  output side_t     side_o
);

  // two lanes in lockstep, one quotient bit per stage
  logic      vld [DivW+1];
  div_lane_t xy  [DivW+1];
  div_lane_t zl  [DivW+1];
  side_t     sd  [DivW+1];

  assign vld[0] = valid_i;
  assign xy[0]  = xy_i;
  assign zl[0]  = z_i;
  assign sd[0]  = side_i;

  for (genvar s = 0; s < DivW; s++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xy[s+1] <= div_step(xy[s]);
        zl[s+1] <= div_step(zl[s]);
        sd[s+1] <= sd[s];
      end
    end
  end

  assign valid_o = vld[DivW];
  assign xy_q_o  = xy[DivW].num;
  assign z_q_o   = zl[DivW].num;
  assign side_o  = sd[DivW];

endmodule

### rtl/core/mtc_back.sv
module mtc_back import mtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  logic [DivW-1:0] xy_q_i,
  input  logic [DivW-1:0] z_q_i,
  input  side_t     side_i,
  input  cfg_t      cfg_i,
  output logic      valid_o,
  output logic [15:0] fx_o,
  output logic [15:0] fy_o,
  output logic [15:0] fz_o,
  output logic      xy_err_o,
  output logic      z_err_o
);

  logic [3:0] v_q;  // stages C..F, output stage separate
  logic       vo_q;

  // stage C: t, t^2, linear term, Z sign fix
  logic [15:0] t;
  logic [31:0] tw, sq, tlin, zq;
  logic [31:0] sq_q, tlin_q;
  logic [15:0] fz_c_q, fz_d_q, fz_e_q, fz_f_q;
  side_t       sc_q, sd_q, se_q, sf_q;

  assign t    = xy_q_i[15:0] - TOffset;
  assign tw   = {{16{t[15]}}, t};
  assign sq   = $signed(tw) * $signed(tw);
  assign tlin = $signed(tw) * $signed({17'd0, cfg_i.xy_pair[7:0], 7'd0});
  assign zq   = side_i.z_neg ? (32'd0 - z_q_i) : z_q_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[2:0], valid_i};
      vo_q <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq;
      tlin_q <= tlin;
      fz_c_q <= side_i.z_err ? 16'd0 : zq[15:0];
      sc_q   <= side_i;
    end
  end

  // stage D: quadratic sum
  logic [31:0] a, a_q;
  assign a = $signed({{24{cfg_i.xy_pair[15]}}, cfg_i.xy_pair[15:8]})
           * $signed(32'($signed(sq_q) >>> 7)) + tlin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a;
      fz_d_q <= fz_c_q;
      sd_q   <= sc_q;
    end
  end

  // stage E: gain multiply per axis
  logic [31:0] b, bx, by, bx_q, by_q;
  assign b  = 32'($signed(a_q) >>> 9) + BOffset;
  assign bx = b * ({{24{cfg_i.x2[7]}}, cfg_i.x2} + GainBase);
  assign by = b * ({{24{cfg_i.y2[7]}}, cfg_i.y2} + GainBase);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx_q   <= bx;
      by_q   <= by;
      fz_e_q <= fz_d_q;
      se_q   <= sd_q;
    end
  end

  // stage F: raw field times scale
  logic [31:0] dx, dy, dx_q, dy_q;
  assign dx = $signed({{19{se_q.rx[12]}}, se_q.rx}) * $signed(32'($signed(bx_q) >>> 12));
  assign dy = $signed({{19{se_q.ry[12]}}, se_q.ry}) * $signed(32'($signed(by_q) >>> 12));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx;
      dy_q   <= dy;
      fz_f_q <= fz_e_q;
      sf_q   <= se_q;
    end
  end

  // stage G: offset, truncate; this is the output register
  logic [31:0] gx, gy;
  assign gx = 32'($signed(dx_q) >>> 13) + ({{24{cfg_i.x1[7]}}, cfg_i.x1} << 3);
  assign gy = 32'($signed(dy_q) >>> 13) + ({{24{cfg_i.y1[7]}}, cfg_i.y1} << 3);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_o     <= sf_q.xy_err ? 16'd0 : gx[15:0];
      fy_o     <= sf_q.xy_err ? 16'd0 : gy[15:0];
      fz_o     <= fz_f_q;
      xy_err_o <= sf_q.xy_err;
      z_err_o  <= sf_q.z_err;
    end
  end

  assign valid_o = vo_q;

endmodule
